/* hdl/crb_pkg.sv */
// Shared types and constants for the clipped rectangle blit block.
`default_nettype none
package crb_pkg;

    localparam int COORD_BITS = 12;
    localparam int SRC_BITS   = 16;
    localparam int EXT_BITS   = SRC_BITS + 1;
    localparam int WORD_BITS  = 16;
    localparam int INDEX_BITS = 2;
    localparam int STEP_BITS  = 4;

    localparam logic [COORD_BITS-1:0] CLIP_LEFT_RESET   = COORD_BITS'(0);
    localparam logic [COORD_BITS-1:0] CLIP_RIGHT_RESET  = COORD_BITS'(480);
    localparam logic [COORD_BITS-1:0] CLIP_TOP_RESET    = COORD_BITS'(0);
    localparam logic [COORD_BITS-1:0] CLIP_BOTTOM_RESET = COORD_BITS'(272);

    localparam logic [WORD_BITS-1:0] CMD_COLUMN = 16'h002A;
    localparam logic [WORD_BITS-1:0] CMD_ROW    = 16'h002B;
    localparam logic [WORD_BITS-1:0] CMD_WRITE  = 16'h002C;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_CLIP_LEFT   = 2'd0,
        REG_CLIP_RIGHT  = 2'd1,
        REG_CLIP_TOP    = 2'd2,
        REG_CLIP_BOTTOM = 2'd3
    } reg_index_t;

    typedef enum logic [STEP_BITS-1:0] {
        STEP_CMD_COLUMN = 4'd0,
        STEP_COL_LO_HI  = 4'd1,
        STEP_COL_LO_LO  = 4'd2,
        STEP_COL_HI_HI  = 4'd3,
        STEP_COL_HI_LO  = 4'd4,
        STEP_CMD_ROW    = 4'd5,
        STEP_ROW_LO_HI  = 4'd6,
        STEP_ROW_LO_LO  = 4'd7,
        STEP_ROW_HI_HI  = 4'd8,
        STEP_ROW_HI_LO  = 4'd9,
        STEP_CMD_WRITE  = 4'd10
    } hdr_step_t;

    typedef struct packed {
        logic                  reject;
        logic [COORD_BITS-1:0] win_left;
        logic [COORD_BITS-1:0] win_right;
        logic [COORD_BITS-1:0] win_top;
        logic [COORD_BITS-1:0] win_bottom;
    } hdr_clip_t;

    // Widen a window coordinate for signed comparison with source coordinates.
    function automatic logic signed [EXT_BITS-1:0] win_ext(input logic [COORD_BITS-1:0] v);
        win_ext = signed'({{(EXT_BITS-COORD_BITS){1'b0}}, v});
    endfunction

    function automatic logic signed [EXT_BITS-1:0] src_ext(input logic [SRC_BITS-1:0] v);
        src_ext = signed'({v[SRC_BITS-1], v});
    endfunction

endpackage
`default_nettype wire

/* hdl/crb_item_if.sv */
// Input item channel: rectangle headers and pixels.
`default_nettype none
interface crb_item_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] rect_left;
    logic [15:0] rect_right;
    logic [15:0] rect_top;
    logic [15:0] rect_bottom;
    logic [15:0] pixel;

    modport source (output valid, mode, rect_left, rect_right, rect_top, rect_bottom, pixel,
                    input ready);
    modport sink   (input valid, mode, rect_left, rect_right, rect_top, rect_bottom, pixel,
                    output ready);
endinterface
`default_nettype wire

/* hdl/crb_result_if.sv */
// Result channel: words for the LCD bus.
`default_nettype none
interface crb_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_word;
    logic        is_command;
    logic        last;

    modport source (output valid, bus_word, is_command, last, input ready);
    modport sink   (input valid, bus_word, is_command, last, output ready);
endinterface
`default_nettype wire

/* hdl/crb_cfg_if.sv */
// Configuration write channel.
`default_nettype none
interface crb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [crb_pkg::INDEX_BITS-1:0]    index;
    logic [crb_pkg::COORD_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/crb_clip.sv */
// Header check and clipping of a source rectangle against the window.
`default_nettype none
module crb_clip (
    input  wire logic [crb_pkg::SRC_BITS-1:0]   rect_left,
    input  wire logic [crb_pkg::SRC_BITS-1:0]   rect_right,
    input  wire logic [crb_pkg::SRC_BITS-1:0]   rect_top,
    input  wire logic [crb_pkg::SRC_BITS-1:0]   rect_bottom,
    input  wire logic [crb_pkg::COORD_BITS-1:0] clip_left,
    input  wire logic [crb_pkg::COORD_BITS-1:0] clip_right,
    input  wire logic [crb_pkg::COORD_BITS-1:0] clip_top,
    input  wire logic [crb_pkg::COORD_BITS-1:0] clip_bottom,
    output crb_pkg::hdr_clip_t                  clip
);
    logic signed [crb_pkg::EXT_BITS-1:0] l, r, t, b;
    logic signed [crb_pkg::EXT_BITS-1:0] ml, mr, mt, mb;

    always_comb
    begin
        l  = crb_pkg::src_ext(rect_left);
        r  = crb_pkg::src_ext(rect_right);
        t  = crb_pkg::src_ext(rect_top);
        b  = crb_pkg::src_ext(rect_bottom);
        ml = crb_pkg::win_ext(clip_left);
        mr = crb_pkg::win_ext(clip_right);
        mt = crb_pkg::win_ext(clip_top);
        mb = crb_pkg::win_ext(clip_bottom);

        // Drop inverted rectangles and those wholly outside the window.
        clip.reject = (l > r) || (t > b) || (l > mr) || (r < ml) || (t > mb) || (b < mt);

        // Only meaningful when accepted; every value then lies inside 0..max coord.
        clip.win_left   = (l < ml) ? clip_left   : l[crb_pkg::COORD_BITS-1:0];
        clip.win_right  = (r > mr) ? clip_right  : r[crb_pkg::COORD_BITS-1:0];
        clip.win_top    = (t < mt) ? clip_top    : t[crb_pkg::COORD_BITS-1:0];
        clip.win_bottom = (b > mb) ? clip_bottom : b[crb_pkg::COORD_BITS-1:0];
    end
endmodule
`default_nettype wire

/* hdl/clipped_rect_blit_to_lcd_bus_core.sv */
// Top level of the clipped rectangle blit to LCD bus block.
//
// Channels: item (sink) carries a rectangle header (mode 0) or a pixel (mode 1);
// result (source) carries LCD bus words with a command flag and a last flag;
// cfg (sink) writes the four clip window registers and is always ready.
// An accepted item lands in an input register; its result word, if any, is
// then loaded into the output register once that register has room. Pixels
// sustain one beat per cycle while the receiver is ready. A header that
// passes the window check emits eleven beats from the input register, one per
// cycle while the receiver is ready, holding off new items for that time; a
// rejected header or a dropped pixel passes through with no beat.
// Reset clears the rectangle state, the clip window returns to columns 0..480
// and rows 0..272, and both registers empty. When the receiver stalls the
// output register holds its beat, the input register holds its item, and the
// item channel drops ready until space frees up. Configuration writes belong
// in idle periods only.
`default_nettype none
module clipped_rect_blit_to_lcd_bus_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    crb_item_if.sink   item,
    crb_result_if.source result,
    crb_cfg_if.sink    cfg
);
    localparam int CB = crb_pkg::COORD_BITS;
    localparam int SB = crb_pkg::SRC_BITS;
    localparam int WB = crb_pkg::WORD_BITS;

    logic [CB-1:0] clip_left_reg, clip_right_reg, clip_top_reg, clip_bottom_reg;

    logic          s1_valid_reg;
    logic          s1_mode_reg;
    logic [SB-1:0] s1_left_reg, s1_right_reg, s1_top_reg, s1_bottom_reg;
    logic [WB-1:0] s1_pixel_reg;

    logic          live_reg;
    logic [SB-1:0] src_left_reg, src_right_reg, pos_x_reg, pos_y_reg;
    logic [CB-1:0] win_left_reg, win_right_reg, win_top_reg, win_bottom_reg;
    crb_pkg::hdr_step_t step_reg, step_next;

    logic          res_valid_reg;
    logic [WB-1:0] res_word_reg;
    logic          res_cmd_reg;
    logic          res_last_reg;

    crb_pkg::hdr_clip_t clip;
    logic          slot_free, accept, emit, s1_done, in_win, row_end;
    logic [SB-1:0] pos_y_inc;
    logic [WB-1:0] emit_word;
    logic          emit_cmd, emit_last;
    crb_pkg::reg_index_t cfg_idx;

    crb_clip u_clip (
        .rect_left   (s1_left_reg),
        .rect_right  (s1_right_reg),
        .rect_top    (s1_top_reg),
        .rect_bottom (s1_bottom_reg),
        .clip_left   (clip_left_reg),
        .clip_right  (clip_right_reg),
        .clip_top    (clip_top_reg),
        .clip_bottom (clip_bottom_reg),
        .clip        (clip)
    );

    assign cfg.ready = 1'b1;
    assign cfg_idx   = crb_pkg::reg_index_t'(cfg.index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= crb_pkg::CLIP_LEFT_RESET;
            clip_right_reg  <= crb_pkg::CLIP_RIGHT_RESET;
            clip_top_reg    <= crb_pkg::CLIP_TOP_RESET;
            clip_bottom_reg <= crb_pkg::CLIP_BOTTOM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx)
                crb_pkg::REG_CLIP_LEFT:   clip_left_reg   <= cfg.data;
                crb_pkg::REG_CLIP_RIGHT:  clip_right_reg  <= cfg.data;
                crb_pkg::REG_CLIP_TOP:    clip_top_reg    <= cfg.data;
                crb_pkg::REG_CLIP_BOTTOM: clip_bottom_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        slot_free = !res_valid_reg || result.ready;
        in_win = (crb_pkg::src_ext(pos_x_reg) >= crb_pkg::win_ext(win_left_reg))
              && (crb_pkg::src_ext(pos_x_reg) <= crb_pkg::win_ext(win_right_reg))
              && (crb_pkg::src_ext(pos_y_reg) >= crb_pkg::win_ext(win_top_reg))
              && (crb_pkg::src_ext(pos_y_reg) <= crb_pkg::win_ext(win_bottom_reg));
        row_end   = crb_pkg::src_ext(pos_x_reg) >= crb_pkg::src_ext(src_right_reg);
        pos_y_inc = pos_y_reg + SB'(1);

        if (!s1_mode_reg)
        begin
            emit    = s1_valid_reg && slot_free && !clip.reject;
            s1_done = s1_valid_reg
                   && (clip.reject || (slot_free && step_reg == crb_pkg::STEP_CMD_WRITE));
        end
        else
        begin
            emit    = s1_valid_reg && slot_free && live_reg && in_win;
            s1_done = s1_valid_reg && (slot_free || !live_reg || !in_win);
        end

        item.ready = !s1_valid_reg || s1_done;
        accept     = item.valid && item.ready;

        step_next = step_reg;
        if (s1_done)
            step_next = crb_pkg::STEP_CMD_COLUMN;
        else if (emit && !s1_mode_reg)
            step_next = crb_pkg::hdr_step_t'(step_reg + crb_pkg::STEP_BITS'(1));

        // Pick the header word for this step; a pixel passes straight through.
        emit_cmd  = 1'b0;
        emit_last = 1'b0;
        emit_word = s1_pixel_reg;
        if (!s1_mode_reg)
        begin
            case (step_reg)
                crb_pkg::STEP_CMD_COLUMN:
                begin
                    emit_word = crb_pkg::CMD_COLUMN;
                    emit_cmd  = 1'b1;
                end
                crb_pkg::STEP_COL_LO_HI: emit_word = WB'(clip.win_left >> 8);
                crb_pkg::STEP_COL_LO_LO: emit_word = WB'(clip.win_left[7:0]);
                crb_pkg::STEP_COL_HI_HI: emit_word = WB'(clip.win_right >> 8);
                crb_pkg::STEP_COL_HI_LO: emit_word = WB'(clip.win_right[7:0]);
                crb_pkg::STEP_CMD_ROW:
                begin
                    emit_word = crb_pkg::CMD_ROW;
                    emit_cmd  = 1'b1;
                end
                crb_pkg::STEP_ROW_LO_HI: emit_word = WB'(clip.win_top >> 8);
                crb_pkg::STEP_ROW_LO_LO: emit_word = WB'(clip.win_top[7:0]);
                crb_pkg::STEP_ROW_HI_HI: emit_word = WB'(clip.win_bottom >> 8);
                crb_pkg::STEP_ROW_HI_LO: emit_word = WB'(clip.win_bottom[7:0]);
                crb_pkg::STEP_CMD_WRITE:
                begin
                    emit_word = crb_pkg::CMD_WRITE;
                    emit_cmd  = 1'b1;
                    emit_last = 1'b1;
                end
                default: emit_word = crb_pkg::CMD_WRITE;
            endcase
        end
        else
        begin
            emit_last = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= item.mode;
            s1_left_reg   <= item.rect_left;
            s1_right_reg  <= item.rect_right;
            s1_top_reg    <= item.rect_top;
            s1_bottom_reg <= item.rect_bottom;
            s1_pixel_reg  <= item.pixel;
        end
    end

    // Rectangle state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= 1'b0;
            step_reg       <= crb_pkg::STEP_CMD_COLUMN;
            src_left_reg   <= '0;
            src_right_reg  <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            win_left_reg   <= '0;
            win_right_reg  <= '0;
            win_top_reg    <= '0;
            win_bottom_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            if (s1_done && !s1_mode_reg)
            begin
                live_reg <= !clip.reject;
                if (!clip.reject)
                begin
                    src_left_reg   <= s1_left_reg;
                    src_right_reg  <= s1_right_reg;
                    pos_x_reg      <= s1_left_reg;
                    pos_y_reg      <= s1_top_reg;
                    win_left_reg   <= clip.win_left;
                    win_right_reg  <= clip.win_right;
                    win_top_reg    <= clip.win_top;
                    win_bottom_reg <= clip.win_bottom;
                end
            end
            else if (s1_done && live_reg)
            begin
                // Advance over every pixel, wrapping at the source row end.
                if (row_end)
                begin
                    pos_x_reg <= src_left_reg;
                    pos_y_reg <= pos_y_inc;
                    if (crb_pkg::src_ext(pos_y_inc) > crb_pkg::win_ext(win_bottom_reg))
                        live_reg <= 1'b0;
                end
                else
                begin
                    pos_x_reg <= pos_x_reg + SB'(1);
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (emit)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_word_reg <= emit_word;
            res_cmd_reg  <= emit_cmd;
            res_last_reg <= emit_last;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.bus_word   = res_word_reg;
    assign result.is_command = res_cmd_reg;
    assign result.last       = res_last_reg;
endmodule
`default_nettype wire
